// File: src/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Clocked assertion, skipped while reset is asserted.
`define MAVF_ASSERT(lbl, clk, rstn, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
	else $error("assertion failed");
// Clocked assertion, also checked during reset.
`define MAVF_ASSERT_ALWAYS(lbl, clk, prop) \
	lbl: assert property (@(posedge clk) prop) else $error("assertion failed");
`endif

// File: src/mavf_pkg.sv
`timescale 1ns / 1ps
package mavf_pkg;
	localparam int MED_DEPTH = 16;
	localparam int AVG_DEPTH = 16;
	localparam int MED_IW = (MED_DEPTH > 1) ? $clog2(MED_DEPTH) : 1;
	localparam int AVG_IW = (AVG_DEPTH > 1) ? $clog2(AVG_DEPTH) : 1;
	localparam int MED_NW = $clog2(MED_DEPTH + 1);
	localparam int AVG_NW = $clog2(AVG_DEPTH + 1);
	localparam int SIZE_W = 5;
	localparam int DATA_W = 16;
	localparam int SUM_W = DATA_W + AVG_NW;
	localparam int DIV_CW = $clog2(SUM_W + 1);
	localparam int IDX_W = 4;
	localparam logic [IDX_W-1:0] REG_MEDIAN_SIZE = IDX_W'(0);
	localparam logic [IDX_W-1:0] REG_AVERAGE_SIZE = IDX_W'(1);

	typedef struct packed {
		logic              valid;
		logic [DATA_W-1:0] sample;
	} mavf_item_t;

	typedef struct packed {
		logic               median_we;
		logic               average_we;
		logic [SIZE_W-1:0]  data;
	} mavf_cfg_t;
endpackage

// File: src/mavf_front.sv
`timescale 1ns / 1ps
module mavf_front (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            sample_valid,
	output logic                            sample_stall,
	input  logic [mavf_pkg::DATA_W-1:0]     sample,
	output mavf_pkg::mavf_item_t            head,
	input  logic                            pop
);
	import mavf_pkg::*;

	logic [DATA_W-1:0] data_q [2];
	logic              rd_q, wr_q;
	logic [1:0]        cnt_q;
	logic              push;

	assign sample_stall = (cnt_q == 2'd2);
	assign push = sample_valid && !sample_stall;
	assign head.valid = (cnt_q != 2'd0);
	assign head.sample = data_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			data_q[wr_q] <= sample;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q <= 1'b0;
			wr_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_q <= ~wr_q;
			if (pop) rd_q <= ~rd_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end
endmodule

// File: src/mavf_back.sv
`timescale 1ns / 1ps
module mavf_back (
	input  logic                         clk,
	input  logic                         arst_n,
	input  mavf_pkg::mavf_cfg_t          cfg,
	input  mavf_pkg::mavf_item_t         head,
	output logic                         pop,
	output logic                         filtered_valid,
	input  logic                         filtered_stall,
	output logic [mavf_pkg::DATA_W-1:0]  filtered
);
	import mavf_pkg::*;

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_MED  = 5'b00010,
		ST_AVG  = 5'b00100,
		ST_DIV  = 5'b01000,
		ST_DONE = 5'b10000
	} state_t;

	function automatic logic [SIZE_W-1:0] clamp(input logic [SIZE_W-1:0] v, input int depth);
		logic [SIZE_W-1:0] r;
		r = v;
		if (v == '0) r = SIZE_W'(1);
		else if (32'(v) > depth) r = SIZE_W'(depth);
		return r;
	endfunction

	state_t              state_q;
	logic [SIZE_W-1:0]   med_size_q, avg_size_q;
	logic [DATA_W-1:0]   mwin_q [MED_DEPTH];
	logic [DATA_W-1:0]   awin_q [AVG_DEPTH];
	logic [MED_IW-1:0]   mpos_q, scan_q;
	logic [MED_NW-1:0]   mfill_q;
	logic [AVG_IW-1:0]   apos_q;
	logic [AVG_NW-1:0]   afill_q;
	logic [SUM_W-1:0]    sum_q;
	logic [DATA_W-1:0]   med_q;
	logic [SUM_W-1:0]    quo_q;
	logic [AVG_NW-1:0]   rem_q, div_q;
	logic [DIV_CW-1:0]   bit_q;
	logic                out_v_q;
	logic [DATA_W-1:0]   out_q;

	logic [MED_NW-1:0]   mn, mk, lt_cnt, le_cnt, mpos_inc;
	logic [AVG_NW-1:0]   an, apos_inc;
	logic [DATA_W-1:0]   cand;
	logic [SUM_W-1:0]    sum_new;
	logic [AVG_NW:0]     trial;
	logic                clear;

	assign clear = cfg.median_we || cfg.average_we;
	assign mn = MED_NW'(clamp(med_size_q, MED_DEPTH));
	assign an = AVG_NW'(clamp(avg_size_q, AVG_DEPTH));
	assign mk = mn >> 1;
	assign mpos_inc = MED_NW'(mpos_q) + MED_NW'(1);
	assign apos_inc = AVG_NW'(apos_q) + AVG_NW'(1);
	assign cand = mwin_q[scan_q];
	assign sum_new = sum_q - SUM_W'(awin_q[apos_q]) + SUM_W'(med_q);
	assign trial = {rem_q, quo_q[SUM_W-1]};
	assign pop = (state_q == ST_IDLE) && head.valid;
	assign filtered_valid = out_v_q;
	assign filtered = out_q;

	always_comb begin
		lt_cnt = '0;
		le_cnt = '0;
		for (int j = 0; j < MED_DEPTH; j++) begin
			if (MED_NW'(j) < mn) begin
				lt_cnt = lt_cnt + MED_NW'(mwin_q[j] < cand);
				le_cnt = le_cnt + MED_NW'(mwin_q[j] <= cand);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			med_size_q <= SIZE_W'(5);
			avg_size_q <= SIZE_W'(8);
			mpos_q <= '0;
			mfill_q <= '0;
			apos_q <= '0;
			afill_q <= '0;
			sum_q <= '0;
			out_v_q <= 1'b0;
			scan_q <= '0;
			bit_q <= '0;
			for (int j = 0; j < MED_DEPTH; j++) mwin_q[j] <= '0;
			for (int j = 0; j < AVG_DEPTH; j++) awin_q[j] <= '0;
		end else begin
			if (out_v_q && !filtered_stall) out_v_q <= 1'b0;
			if (cfg.median_we) med_size_q <= cfg.data;
			if (cfg.average_we) avg_size_q <= cfg.data;
			if (clear) begin
				mpos_q <= '0;
				mfill_q <= '0;
				apos_q <= '0;
				afill_q <= '0;
				sum_q <= '0;
				for (int j = 0; j < MED_DEPTH; j++) mwin_q[j] <= '0;
				for (int j = 0; j < AVG_DEPTH; j++) awin_q[j] <= '0;
			end else begin
				unique case (state_q)
					ST_IDLE: begin
						if (head.valid) begin
							mwin_q[mpos_q] <= head.sample;
							mpos_q <= (mpos_inc >= mn) ? '0 : mpos_inc[MED_IW-1:0];
							scan_q <= '0;
							if (mfill_q < mn) begin
								mfill_q <= mfill_q + MED_NW'(1);
								med_q <= head.sample;
								state_q <= ST_AVG;
							end else begin
								state_q <= ST_MED;
							end
						end
					end
					ST_MED: begin
						if (lt_cnt <= mk && mk < le_cnt) begin
							med_q <= cand;
							state_q <= ST_AVG;
						end else begin
							scan_q <= scan_q + MED_IW'(1);
						end
					end
					ST_AVG: begin
						sum_q <= sum_new;
						awin_q[apos_q] <= med_q;
						apos_q <= (apos_inc >= an) ? '0 : apos_inc[AVG_IW-1:0];
						if (afill_q < an) begin
							afill_q <= afill_q + AVG_NW'(1);
							div_q <= afill_q + AVG_NW'(1);
						end else begin
							div_q <= an;
						end
						quo_q <= sum_new;
						rem_q <= '0;
						bit_q <= '0;
						state_q <= ST_DIV;
					end
					ST_DIV: begin
						if (trial >= {1'b0, div_q}) begin
							rem_q <= AVG_NW'(trial - {1'b0, div_q});
							quo_q <= {quo_q[SUM_W-2:0], 1'b1};
						end else begin
							rem_q <= trial[AVG_NW-1:0];
							quo_q <= {quo_q[SUM_W-2:0], 1'b0};
						end
						bit_q <= bit_q + DIV_CW'(1);
						if (bit_q == DIV_CW'(SUM_W - 1)) state_q <= ST_DONE;
					end
					ST_DONE: begin
						if (!out_v_q) begin
							out_q <= quo_q[DATA_W-1:0];
							out_v_q <= 1'b1;
							state_q <= ST_IDLE;
						end
					end
					default: state_q <= ST_IDLE;
				endcase
			end
		end
	end
endmodule

// File: src/median_then_moving_average_filter_core.sv
`timescale 1ns / 1ps
// Path from sample transfer to filtered valid: input queue, IDLE (pop), MED (rank scan
// over the median window, skipped while it fills), AVG, DIV, DONE; a held output stalls DONE.
// A new sample is popped only once the last has left DONE, after the rank scan and the
// 21-step restoring divider. A two-entry input queue absorbs bursts.
// Reset (arst_n low, asynchronous): sizes go to 5 and 8, all windows, sums and
// fill counts clear. A size register write clears both stages the same way.
module median_then_moving_average_filter_core (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_en,
	input  logic [mavf_pkg::IDX_W-1:0]        cfg_index,
	input  logic [mavf_pkg::SIZE_W-1:0]       cfg_data,
	input  logic                              sample_valid,
	output logic                              sample_stall,
	input  logic [mavf_pkg::DATA_W-1:0]       sample,
	output logic                              filtered_valid,
	input  logic                              filtered_stall,
	output logic [mavf_pkg::DATA_W-1:0]       filtered
);
	import mavf_pkg::*;

	mavf_item_t head;
	mavf_cfg_t  cfg;
	logic       pop;

	assign cfg.median_we = cfg_en && (cfg_index == REG_MEDIAN_SIZE);
	assign cfg.average_we = cfg_en && (cfg_index == REG_AVERAGE_SIZE);
	assign cfg.data = cfg_data;

	mavf_front u_front (
		.clk(clk), .arst_n(arst_n),
		.sample_valid(sample_valid), .sample_stall(sample_stall), .sample(sample),
		.head(head), .pop(pop)
	);

	mavf_back u_back (
		.clk(clk), .arst_n(arst_n), .cfg(cfg), .head(head), .pop(pop),
		.filtered_valid(filtered_valid), .filtered_stall(filtered_stall),
		.filtered(filtered)
	);
endmodule

// File: src/mavf_checker.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
module mavf_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          filtered_valid,
	input logic                          filtered_stall,
	input logic [mavf_pkg::DATA_W-1:0]   filtered
);
	import mavf_pkg::*;

	`MAVF_ASSERT(a_out_hold, clk, arst_n, filtered_valid && filtered_stall |=> filtered_valid)
	`MAVF_ASSERT(a_out_stable, clk, arst_n, filtered_valid && filtered_stall |=> $stable(filtered))
	`MAVF_ASSERT(a_out_gap, clk, arst_n, filtered_valid && !filtered_stall |=> !filtered_valid)
	`MAVF_ASSERT_ALWAYS(a_reset_quiet, clk, !arst_n |-> !filtered_valid)
endmodule

bind median_then_moving_average_filter_core mavf_checker u_mavf_checker (
	.clk(clk), .arst_n(arst_n), .filtered_valid(filtered_valid),
	.filtered_stall(filtered_stall), .filtered(filtered)
);

// File: test/median_then_moving_average_filter_core_tb.sv
`timescale 1ns / 1ps
module median_then_moving_average_filter_core_tb;
	import mavf_pkg::*;

	localparam int WATCHDOG_LIMIT = 20000;
	localparam int DRAIN_CYCLES = 80;

	logic clk;
	logic arst_n;
	logic cfg_en;
	logic [IDX_W-1:0] cfg_index;
	logic [SIZE_W-1:0] cfg_data;
	logic sample_valid;
	logic sample_stall;
	logic [DATA_W-1:0] sample;
	logic filtered_valid;
	logic filtered_stall;
	logic [DATA_W-1:0] filtered;

	median_then_moving_average_filter_core u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_en(cfg_en),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.sample_valid(sample_valid),
		.sample_stall(sample_stall),
		.sample(sample),
		.filtered_valid(filtered_valid),
		.filtered_stall(filtered_stall),
		.filtered(filtered)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// predictor state
	logic [SIZE_W-1:0] med_size_reg;
	logic [SIZE_W-1:0] avg_size_reg;
	logic [DATA_W-1:0] med_win [MED_DEPTH];
	logic [DATA_W-1:0] avg_win [AVG_DEPTH];
	int unsigned med_pos, med_fill, avg_pos, avg_fill;
	int unsigned run_sum;

	logic [DATA_W-1:0] expected_filtered [$];
	int mismatches;
	int idle_cycles;
	bit calm;
	bit hold_receiver;
	int hold_len;

	function automatic int unsigned clamp_len(logic [SIZE_W-1:0] v, int depth);
		if (v == 0)
			return 1;
		if (v > depth)
			return depth;
		return v;
	endfunction

	task automatic clear_filter_state();
		for (int i = 0; i < MED_DEPTH; i++)
			med_win[i] = '0;
		for (int i = 0; i < AVG_DEPTH; i++)
			avg_win[i] = '0;
		med_pos = 0;
		med_fill = 0;
		avg_pos = 0;
		avg_fill = 0;
		run_sum = 0;
	endtask

	function automatic logic [DATA_W-1:0] median_of_window(logic [DATA_W-1:0] x);
		int unsigned n;
		logic [DATA_W-1:0] srt [MED_DEPTH];
		logic [DATA_W-1:0] v;
		int j;
		n = clamp_len(med_size_reg, MED_DEPTH);
		if (med_pos >= n)
			med_pos = 0;
		med_win[med_pos] = x;
		med_pos++;
		if (med_pos >= n)
			med_pos = 0;
		if (med_fill < n) begin
			med_fill++;
			return x;
		end
		for (int i = 0; i < n; i++) begin
			v = med_win[i];
			j = i;
			while (j > 0 && srt[j-1] > v) begin
				srt[j] = srt[j-1];
				j--;
			end
			srt[j] = v;
		end
		return srt[n/2];
	endfunction

	function automatic logic [DATA_W-1:0] average_of_medians(logic [DATA_W-1:0] x);
		int unsigned n;
		n = clamp_len(avg_size_reg, AVG_DEPTH);
		if (avg_pos >= n)
			avg_pos = 0;
		run_sum = run_sum - avg_win[avg_pos] + x;
		avg_win[avg_pos] = x;
		avg_pos++;
		if (avg_pos >= n)
			avg_pos = 0;
		if (avg_fill < n) begin
			avg_fill++;
			return DATA_W'(run_sum / avg_fill);
		end
		return DATA_W'(run_sum / n);
	endfunction

	// valid stays high after a transfer until the next item or an idle cycle drops it
	task automatic send_sample(logic [DATA_W-1:0] x);
		while (!calm && $urandom_range(99) < 10) begin
			sample_valid <= 1'b0;
			@(negedge clk);
		end
		sample <= x;
		sample_valid <= 1'b1;
		@(posedge clk);
		while (sample_stall)
			@(posedge clk);
		expected_filtered.push_back(average_of_medians(median_of_window(x)));
		@(negedge clk);
	endtask

	task automatic wait_drained();
		sample_valid <= 1'b0;
		while (expected_filtered.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(logic [IDX_W-1:0] idx, logic [SIZE_W-1:0] val);
		wait_drained();
		cfg_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_en <= 1'b0;
		if (idx == REG_MEDIAN_SIZE) begin
			med_size_reg = val;
			clear_filter_state();
		end else if (idx == REG_AVERAGE_SIZE) begin
			avg_size_reg = val;
			clear_filter_state();
		end
	endtask

	// filtered checker
	always @(posedge clk) begin
		if (arst_n && filtered_valid && !filtered_stall) begin
			idle_cycles <= 0;
			if (expected_filtered.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected filtered transfer %h", filtered);
			end else if (filtered !== expected_filtered[0]) begin
				mismatches++;
				if (mismatches <= 10)
					$display("filtered mismatch: expected %h actual %h",
						expected_filtered[0], filtered);
				void'(expected_filtered.pop_front());
			end else begin
				void'(expected_filtered.pop_front());
			end
		end else if (sample_valid && !sample_stall) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("median_then_moving_average_filter_core_tb failed");
				$finish;
			end
		end
	end

	// receiver stall
	always @(negedge clk) begin
		if (hold_len > 0) begin
			filtered_stall <= 1'b1;
			hold_len <= hold_len - 1;
		end else if (hold_receiver) begin
			hold_receiver <= 1'b0;
			hold_len <= 400;
			filtered_stall <= 1'b1;
		end else begin
			filtered_stall <= !calm && ($urandom_range(99) < 10);
		end
	end

	task automatic test_directed_extremes();
		write_reg(REG_MEDIAN_SIZE, 5'd3);
		write_reg(REG_AVERAGE_SIZE, 5'd2);
		send_sample(16'h0000);
		send_sample(16'hFFFF);
		send_sample(16'hFFFF);
		send_sample(16'h0000);
		send_sample(16'h5555);
		send_sample(16'hAAAA);
		send_sample(16'hFFFF);
		write_reg(REG_MEDIAN_SIZE, 5'd0);
		write_reg(REG_AVERAGE_SIZE, 5'd0);
		send_sample(16'hFFFF);
		send_sample(16'h0001);
		write_reg(REG_MEDIAN_SIZE, 5'd31);
		write_reg(REG_AVERAGE_SIZE, 5'd31);
		for (int i = 0; i < 18; i++)
			send_sample(16'hFFFF - i);
		write_reg(REG_AVERAGE_SIZE, 5'd31);
		send_sample(16'h1234);
		wait_drained();
		cfg_en <= 1'b1;
		cfg_index <= 4'hF;
		cfg_data <= 5'd1;
		@(negedge clk);
		cfg_en <= 1'b0;
		send_sample(16'h4321);
	endtask

	task automatic test_backpressure();
		write_reg(REG_MEDIAN_SIZE, 5'd16);
		write_reg(REG_AVERAGE_SIZE, 5'd16);
		hold_receiver = 1'b1;
		for (int i = 0; i < 30; i++)
			send_sample(16'($urandom));
		wait_drained();
	endtask

	task automatic test_random_phases();
		for (int ph = 0; ph < 18; ph++) begin
			write_reg(REG_MEDIAN_SIZE, (ph % 3 == 0) ? SIZE_W'($urandom) :
				SIZE_W'($urandom_range(1, 5)));
			write_reg(REG_AVERAGE_SIZE, (ph % 3 == 1) ? SIZE_W'($urandom) :
				SIZE_W'($urandom_range(1, 6)));
			calm = (ph == 7);
			for (int i = 0; i < 100; i++) begin
				case ($urandom_range(3))
					0: send_sample(16'($urandom));
					1: send_sample(16'($urandom_range(0, 15)));
					2: send_sample(16'hFFFF - 16'($urandom_range(0, 15)));
					default: send_sample(16'h8000 ^ 16'($urandom_range(0, 255)));
				endcase
			end
			calm = 1'b0;
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_en = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		sample_valid = 1'b0;
		sample = '0;
		filtered_stall = 1'b0;
		mismatches = 0;
		idle_cycles = 0;
		calm = 1'b0;
		hold_receiver = 1'b0;
		hold_len = 0;
		med_size_reg = 5'd5;
		avg_size_reg = 5'd8;
		clear_filter_state();
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		for (int i = 0; i < 6; i++)
			send_sample(16'($urandom));
		test_directed_extremes();
		test_backpressure();
		test_random_phases();
		wait_drained();
		if (mismatches == 0 && expected_filtered.size() == 0)
			$display("median_then_moving_average_filter_core_tb passed");
		else
			$display("median_then_moving_average_filter_core_tb failed");
		$finish;
	end
endmodule
